@@ design/spq_pkg.sv @@
// Shared types and constants of the stable priority queue.
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } st_t;

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  tag_a;
        logic [7:0]  tag_b;
        logic [7:0]  level;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_t;

    typedef struct packed {
        st_t              status;
        entry_t           ent;
        logic [OCC_W-1:0] occupancy;
    } res_t;

endpackage

@@ design/spq_req_if.sv @@
// Request channel: valid/ready handshake with one queue request word.
interface spq_req_if import spq_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [7:0]  tag_a;
    logic [7:0]  tag_b;
    logic [7:0]  level;

    modport source (output valid, output req_type, output key, output tag_a,
                    output tag_b, output level, input ready);
    modport sink   (input valid, input req_type, input key, input tag_a,
                    input tag_b, input level, output ready);
endinterface

@@ design/spq_rsp_if.sv @@
// Response channel: valid/ready handshake with one queue result word.
interface spq_rsp_if import spq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [15:0]      out_key;
    logic [7:0]       out_tag_a;
    logic [7:0]       out_tag_b;
    logic [7:0]       out_level;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output out_key, output out_tag_a,
                    output out_tag_b, output out_level, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input out_key, input out_tag_a,
                    input out_tag_b, input out_level, input occupancy,
                    output ready);
endinterface

@@ design/stable_priority_queue_unit.sv @@
// Stable priority queue: a sorted list of up to DEPTH entries, served lowest level first.
//
// Use: the req channel carries one request word (insert, pop, search by key); the
// rsp channel returns exactly one result word per request, in request order, with
// a status, the popped or found entry (zeros otherwise) and the entry count.
// Ties in level leave in arrival order; pop and search work from the head.
// Entries sit in a circular buffer in one memory; one comparator under a small
// sequencer visits the slots one at a time (memory read, then compare).
// Work per request: pop reads the head slot and removes it; search reads slots
//   from the head until a key matches or the list ends; insert reads from the
//   tail, moves each entry of higher level one slot toward the tail, and writes
//   the new entry where the walk meets a lower or equal level or reaches the head;
//   refused requests, empty-queue cases and the no-op code go straight to a result.
// One request is worked on at a time: req.ready is low from acceptance until the
// result has moved into the output register, which then waits on rsp.ready while
// the next request is taken.
// Reset empties the queue at once; memory contents need no clearing.
// A stalled receiver holds the result word steady and, once the sequencer has a
// second result ready, holds off further requests.
module stable_priority_queue_unit import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    entry_t            in_ent;
    wr_t               wr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              res_valid;
    res_t              res;
    logic              res_take;
    logic              out_valid_reg;
    res_t              out_reg;

    assign in_ent.key   = req.key;
    assign in_ent.tag_a = req.tag_a;
    assign in_ent.tag_b = req.tag_b;
    assign in_ent.level = req.level;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_req    (req_t'(req.req_type)),
        .in_ent    (in_ent),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    spq_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // load the output register when it is empty or its word is leaving
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.out_key   = out_reg.ent.key;
    assign rsp.out_tag_a = out_reg.ent.tag_a;
    assign rsp.out_tag_b = out_reg.ent.tag_b;
    assign rsp.out_level = out_reg.ent.level;
    assign rsp.occupancy = out_reg.occupancy;

endmodule

@@ design/spq_store.sv @@
// Entry memory: one write port, one read port with registered read data.
module spq_store import spq_pkg::*;
(
    input  logic              clk,
    input  wr_t               wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/spq_ctrl.sv @@
// Sequencer: walks the circular entry list one slot per step with one comparator.
module spq_ctrl import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  req_t              in_req,
    input  entry_t            in_ent,
    output wr_t               wr,
    output logic [ADDR_W-1:0] rd_addr,
    input  entry_t            rd_data,
    output logic              res_valid,
    output res_t              res,
    input  logic              res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_PUT,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   idx_reg;
    req_t               req_reg;
    entry_t             new_reg;
    entry_t             hit_reg;
    st_t                status_reg;

    // Map a position counted from the head to a slot address.
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [CNT_W-1:0]  pos);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, head} + (ADDR_W+1)'(pos);
            if (sum >= (ADDR_W+1)'(DEPTH))
            begin
                sum = sum - (ADDR_W+1)'(DEPTH);
            end
            return sum[ADDR_W-1:0];
        end
    endfunction

    assign in_ready      = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.ent       = hit_reg;
    assign res.occupancy = OCC_W'(fill_reg);

    always_comb
    begin
        if (req_reg == REQ_INSERT)
        begin
            rd_addr = phys(head_reg, idx_reg - CNT_W'(1));
        end
        else
        begin
            rd_addr = phys(head_reg, idx_reg);
        end
    end

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = phys(head_reg, idx_reg);
        wr.data = new_reg;
        if (state_reg == S_PUT)
        begin
            wr.en = 1'b1;
        end
        else if (state_reg == S_EV && req_reg == REQ_INSERT &&
                 rd_data.level > new_reg.level)
        begin
            // shift the larger entry one slot toward the tail
            wr.en   = 1'b1;
            wr.data = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            req_reg    <= REQ_NONE;
            new_reg    <= '0;
            hit_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg    <= in_req;
                        new_reg    <= in_ent;
                        hit_reg    <= '0;
                        status_reg <= ST_OK;
                        idx_reg    <= '0;
                        unique case (in_req)
                            REQ_INSERT:
                            begin
                                if (fill_reg == CNT_W'(DEPTH))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg   <= fill_reg;
                                    state_reg <= (fill_reg == '0) ? S_PUT : S_RD;
                                end
                            end
                            REQ_POP:
                            begin
                                if (fill_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            REQ_SEARCH:
                            begin
                                if (fill_reg == '0)
                                begin
                                    status_reg <= ST_NOTFOUND;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            REQ_NONE:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    unique case (req_reg)
                        REQ_INSERT:
                        begin
                            if (rd_data.level > new_reg.level)
                            begin
                                idx_reg   <= idx_reg - CNT_W'(1);
                                state_reg <= (idx_reg == CNT_W'(1)) ? S_PUT : S_RD;
                            end
                            else
                            begin
                                state_reg <= S_PUT;
                            end
                        end
                        REQ_POP:
                        begin
                            // advance the head past the removed entry
                            hit_reg   <= rd_data;
                            head_reg  <= phys(head_reg, CNT_W'(1));
                            fill_reg  <= fill_reg - CNT_W'(1);
                            state_reg <= S_DONE;
                        end
                        REQ_SEARCH:
                        begin
                            if (rd_data.key == new_reg.key)
                            begin
                                hit_reg   <= rd_data;
                                state_reg <= S_DONE;
                            end
                            else if (idx_reg + CNT_W'(1) == fill_reg)
                            begin
                                status_reg <= ST_NOTFOUND;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + CNT_W'(1);
                                state_reg <= S_RD;
                            end
                        end
                        REQ_NONE:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_PUT:
                begin
                    fill_reg  <= fill_reg + CNT_W'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
